/* rtl/bmbw_pkg.sv */
`timescale 1ns / 1ps
// bmbw_pkg: shared types and constants for the bus-master block writer
// no dependencies

package bmbw_pkg;

	// transfer phases
	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_GUARD   = 3'd1,
		PH_REQ     = 3'd2,
		PH_SETUP   = 3'd3,
		PH_WRITE   = 3'd4,
		PH_RELEASE = 3'd5
	} phase_t;

	// item operations
	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// result status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_TOO_SMALL  = 3'd1;
	localparam logic [2:0] ST_TOO_BIG    = 3'd2;
	localparam logic [2:0] ST_BAD_STRIDE = 3'd3;
	localparam logic [2:0] ST_BORDER_BIG = 3'd4;
	localparam logic [2:0] ST_CONTENDED  = 3'd5;
	localparam logic [2:0] ST_BUSY       = 3'd6;

	// configuration register indexes
	localparam logic [2:0] REG_MAX_LENGTH     = 3'd0;
	localparam logic [2:0] REG_MAX_STRIDE     = 3'd1;
	localparam logic [2:0] REG_TOP_BORDER_MAX = 3'd2;
	localparam logic [2:0] REG_FAST_HOLD      = 3'd3;
	localparam logic [2:0] REG_SLOW_HOLD      = 3'd4;

	// contended memory window, one bit wider to test the unwrapped end address
	localparam logic [16:0] CONT_LO = 17'h04000;
	localparam logic [16:0] CONT_HI = 17'h07FFF;

	typedef struct packed {
		logic        operation;
		logic [15:0] start_addr;
		logic [15:0] byte_count;
		logic [7:0]  stride;
		logic        top_border;
		logic        skip_int_guard;
		logic        int_guard_enable;
		logic        busack_n;
		logic        irq_unsafe;
		logic [7:0]  source_byte;
	} in_item_t;

	typedef struct packed {
		logic        busreq_n;
		logic        drive_bus;
		logic        mreq_n;
		logic        wr_n;
		logic [15:0] bus_addr;
		logic [7:0]  bus_data;
		logic [23:0] src_offset;
		logic        mirror_we;
		logic [2:0]  status;
		logic        done_res;
	} out_item_t;

	typedef struct packed {
		logic [15:0] max_length;
		logic [7:0]  max_stride;
		logic [15:0] top_border_max;
		logic [7:0]  fast_hold_cycles;
		logic [7:0]  slow_hold_cycles;
	} cfg_t;

endpackage

/* rtl/bmbw_cfg_regs.sv */
`timescale 1ns / 1ps
// bmbw_cfg_regs: configuration register file of the block writer
// depends on bmbw_pkg

module bmbw_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  logic [2:0]     wr_index,
	input  logic [15:0]    wr_data,
	output bmbw_pkg::cfg_t cfg
);
	import bmbw_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_length       <= 16'd16384;
			cfg_q.max_stride       <= 8'd255;
			cfg_q.top_border_max   <= 16'd512;
			cfg_q.fast_hold_cycles <= 8'd37;
			cfg_q.slow_hold_cycles <= 8'd50;
		end else if (wr_en) begin
			case (wr_index)
				REG_MAX_LENGTH:     cfg_q.max_length       <= wr_data;
				REG_MAX_STRIDE:     cfg_q.max_stride       <= wr_data[7:0];
				REG_TOP_BORDER_MAX: cfg_q.top_border_max   <= wr_data;
				REG_FAST_HOLD:      cfg_q.fast_hold_cycles <= wr_data[7:0];
				REG_SLOW_HOLD:      cfg_q.slow_hold_cycles <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/bmbw_ctrl.sv */
`timescale 1ns / 1ps
// bmbw_ctrl: transfer state machine, request checks and per-beat result logic
// depends on bmbw_pkg

module bmbw_ctrl #(
	parameter int ADDR_BITS   = 16,
	parameter int OFFSET_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  bmbw_pkg::in_item_t  item,
	input  bmbw_pkg::cfg_t      cfg,
	output bmbw_pkg::out_item_t res
);
	import bmbw_pkg::*;

	phase_t                 phase_q, phase_d;
	logic [ADDR_BITS-1:0]   cur_addr_q, cur_addr_d;
	logic [15:0]            bytes_left_q, bytes_left_d;
	logic [OFFSET_BITS-1:0] cur_offset_q, cur_offset_d;
	logic [7:0]             stride_q, stride_d;
	logic [7:0]             hold_count_q, hold_count_d;
	logic                   slow_mode_q, slow_mode_d;

	logic [16:0]            end_addr;
	logic                   contended;
	logic [2:0]             code;
	logic                   slow;
	logic [7:0]             hold_value;
	logic [OFFSET_BITS-1:0] next_offset;
	logic                   last_strobe;
	logic                   owns;
	logic                   drive;

	// request checks, in priority order
	always_comb begin
		end_addr  = {1'b0, item.start_addr} + {1'b0, item.byte_count};
		contended = ({1'b0, item.start_addr} >= CONT_LO && {1'b0, item.start_addr} <= CONT_HI)
			|| (end_addr >= CONT_LO && end_addr <= CONT_HI);
		code = ST_OK;
		slow = 1'b1;
		if (item.byte_count == 16'd0) begin
			code = ST_TOO_SMALL;
		end else if (item.byte_count > cfg.max_length) begin
			code = ST_TOO_BIG;
		end else if (item.stride > cfg.max_stride) begin
			code = ST_BAD_STRIDE;
		end else if (contended) begin
			if (!item.top_border) begin
				code = ST_CONTENDED;
			end else if (item.byte_count > cfg.top_border_max) begin
				code = ST_BORDER_BIG;
			end else begin
				slow = 1'b0;
			end
		end
	end

	assign hold_value  = slow_mode_q ? cfg.slow_hold_cycles : cfg.fast_hold_cycles;
	assign next_offset = cur_offset_q + OFFSET_BITS'(stride_q);
	// a hold of zero behaves as one
	assign last_strobe = hold_count_q <= 8'd1;

	// next state
	always_comb begin
		phase_d      = phase_q;
		cur_addr_d   = cur_addr_q;
		bytes_left_d = bytes_left_q;
		cur_offset_d = cur_offset_q;
		stride_d     = stride_q;
		hold_count_d = hold_count_q;
		slow_mode_d  = slow_mode_q;
		if (item.operation == OP_START) begin
			if (phase_q == PH_IDLE && code == ST_OK) begin
				cur_addr_d   = ADDR_BITS'(item.start_addr);
				bytes_left_d = item.byte_count;
				cur_offset_d = '0;
				stride_d     = item.stride;
				slow_mode_d  = slow;
				hold_count_d = 8'd0;
				phase_d      = (item.int_guard_enable && !item.skip_int_guard) ?
					PH_GUARD : PH_REQ;
			end
		end else begin
			case (phase_q)
				PH_GUARD: begin
					if (!item.irq_unsafe) phase_d = PH_REQ;
				end
				PH_REQ: begin
					if (!item.busack_n) begin
						phase_d      = PH_SETUP;
						hold_count_d = hold_value;
					end
				end
				PH_SETUP: phase_d = PH_WRITE;
				PH_WRITE: begin
					if (last_strobe) begin
						cur_addr_d   = cur_addr_q + ADDR_BITS'(1);
						cur_offset_d = next_offset;
						if (bytes_left_q <= 16'd1) begin
							bytes_left_d = 16'd0;
							phase_d      = PH_RELEASE;
						end else begin
							bytes_left_d = bytes_left_q - 16'd1;
							phase_d      = PH_SETUP;
							hold_count_d = hold_value;
						end
					end else begin
						hold_count_d = hold_count_q - 8'd1;
					end
				end
				PH_RELEASE: begin
					if (item.busack_n) phase_d = PH_IDLE;
				end
				default: ;
			endcase
		end
	end

	// result beat
	always_comb begin
		owns = phase_q == PH_REQ || phase_q == PH_SETUP || phase_q == PH_WRITE;
		drive = phase_q == PH_SETUP || phase_q == PH_WRITE;
		res.busreq_n   = !owns;
		res.drive_bus  = drive;
		res.mreq_n     = phase_q != PH_WRITE;
		res.wr_n       = phase_q != PH_WRITE;
		res.bus_addr   = drive ? 16'(cur_addr_q) : 16'd0;
		res.bus_data   = drive ? item.source_byte : 8'd0;
		res.src_offset = owns ? 24'(cur_offset_q) : 24'd0;
		res.mirror_we  = 1'b0;
		res.status     = ST_OK;
		res.done_res   = 1'b0;
		if (item.operation == OP_START) begin
			if (phase_q != PH_IDLE) begin
				res.status   = ST_BUSY;
				res.done_res = 1'b1;
			end else begin
				res.status   = code;
				res.done_res = code != ST_OK;
			end
		end else begin
			case (phase_q)
				PH_GUARD: begin
					if (!item.irq_unsafe) begin
						res.busreq_n   = 1'b0;
						res.src_offset = 24'(cur_offset_q);
					end
				end
				PH_WRITE: begin
					if (last_strobe) begin
						res.mirror_we  = 1'b1;
						res.src_offset = 24'(next_offset);
					end
				end
				PH_RELEASE: begin
					if (item.busack_n) res.done_res = 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			cur_addr_q   <= '0;
			bytes_left_q <= '0;
			cur_offset_q <= '0;
			stride_q     <= '0;
			hold_count_q <= '0;
			slow_mode_q  <= 1'b0;
		end else if (step) begin
			phase_q      <= phase_d;
			cur_addr_q   <= cur_addr_d;
			bytes_left_q <= bytes_left_d;
			cur_offset_q <= cur_offset_d;
			stride_q     <= stride_d;
			hold_count_q <= hold_count_d;
			slow_mode_q  <= slow_mode_d;
		end
	end

endmodule

/* rtl/z80_bus_master_block_writer.sv */
`timescale 1ns / 1ps
// each result beat passes the input register and then the result register
// throughput: one item per cycle unless the output stalls; each tick advances the transfer state machine once
// the input register stalls only while the result register holds an untaken beat
// reset (arst_n low, asynchronous): pipeline empty, phase idle, transfer state cleared,
// configuration registers at their default values; no clearing pass
// depends on bmbw_pkg, bmbw_cfg_regs, bmbw_ctrl

module z80_bus_master_block_writer #(
	parameter int ADDR_BITS   = 16,
	parameter int OFFSET_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  bmbw_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output bmbw_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import bmbw_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t res_s2;
	out_item_t res;
	cfg_t      cfg;
	logic      advance;
	logic      step;

	assign advance   = !valid_s2 || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign step      = valid_s1 && advance;
	assign cfg_ready = 1'b1;

	bmbw_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	bmbw_ctrl #(
		.ADDR_BITS   (ADDR_BITS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && !in_stall) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (advance) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) item_s1 <= in_data;
		if (step) res_s2 <= res;
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

endmodule

/* rtl/bmbw_checker.sv */
`timescale 1ns / 1ps
// bmbw_checker: port-level checks on the result beats of the block writer
// depends on bmbw_pkg; bound to z80_bus_master_block_writer

module bmbw_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input bmbw_pkg::out_item_t out_data
);
	import bmbw_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// a mirror write only happens on a driven strobe cycle
	a_mirror_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.mirror_we |->
			out_data.drive_bus && !out_data.wr_n && !out_data.mreq_n)
		else $error("mirror write outside a write strobe");

	// the bus is only driven while it is requested
	a_drive_owned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.drive_bus |-> !out_data.busreq_n)
		else $error("bus driven without bus request");

	// any error status ends the request
	a_error_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.done_res)
		else $error("error status without done");

endmodule

bind z80_bus_master_block_writer bmbw_checker u_bmbw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
